[hw/rtl/tvlf_pkg.sv]
// Package of the track validity lock filter: item types, register indexes,
// reset values, mode codes, sequencer states and decision codes.
// No dependencies.
package tvlf_pkg;

	localparam int MAX_HISTORY_DEF = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int HLEN_W     = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOCK_THRESHOLD = 3'd0,
		REG_MAX_RANGE      = 3'd1,
		REG_MIN_RANGE      = 3'd2,
		REG_MAX_SHIFT      = 3'd3,
		REG_HISTORY_LENGTH = 3'd4,
		REG_MAX_GAP        = 3'd5
	} reg_index_t;

	localparam logic [7:0]        LOCK_THRESHOLD_RST = 8'd5;
	localparam logic [14:0]       MAX_RANGE_RST      = 15'd20000;
	localparam logic [14:0]       MIN_RANGE_RST      = 15'd0;
	localparam logic [15:0]       MAX_SHIFT_RST      = 16'd500;
	localparam logic [HLEN_W-1:0] HISTORY_LENGTH_RST = 6'd20;
	localparam logic [23:0]       MAX_GAP_RST        = 24'd100000;

	localparam logic [1:0] MODE_STOPPING = 2'd0;
	localparam logic [1:0] MODE_IDLING   = 2'd1;
	localparam logic [1:0] MODE_TRACKING = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NORM,
		S_RANGE,
		S_DIST,
		S_LAST,
		S_UPDATE
	} state_t;

	typedef enum logic [1:0] {
		ACT_LOWER,
		ACT_RAISE,
		ACT_RESTART
	} action_t;

	typedef struct packed {
		logic signed [15:0] x_pos;
		logic signed [15:0] y_pos;
		logic signed [15:0] z_pos;
		logic [23:0]        gap_time;
	} det_item_t;

	typedef struct packed {
		logic       new_track;
		logic [7:0] lock_count;
		logic [1:0] track_mode;
		logic [5:0] match_count;
	} res_item_t;

endpackage

[hw/rtl/tvlf_stream_if.sv]
// Valid/ready stream channel of the track validity lock filter.
// The payload type is a parameter; the item structs come from tvlf_pkg.
interface tvlf_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/track_validity_lock_filter_unit.sv]
// Track validity lock filter, top level.
// Depends on tvlf_pkg and tvlf_stream_if.
//
// Channels: detection (sink) carries one position and its time gap per item;
// report (source) carries one result item per detection. Configuration is
// written through wr_en / wr_index / wr_data, one register per edge; the user
// must write it only while the block is idle, which the block does not enforce.
// Datapath: one 16x16 squaring unit is shared under a small sequencer. It
// squares the three coordinates and the three limits, then the three
// coordinate differences per history entry for the squared distance,
// reading the history memory one entry ahead. An item in range and within
// the gap limit passes S_NORM, S_RANGE, S_DIST for each of the N entries
// in use (20 by default), S_LAST and S_UPDATE; a range reject or a gap
// restart goes from S_RANGE to S_UPDATE. A new item is taken only once the
// last result is registered; detection.ready is high only while idle.
// Reset: registers return to their defaults, lock counter and write
// pointer clear, mode is stopping, and all history valid bits clear at
// once, so unwritten entries read as the origin; no clearing pass.
// Stall: a finished result waits in the output register; the next item is
// accepted meanwhile and holds in its last step until the register frees.
module track_validity_lock_filter_unit #(
	parameter int MAX_HISTORY = tvlf_pkg::MAX_HISTORY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [tvlf_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [tvlf_pkg::CFG_DATA_W-1:0]  wr_data,
	tvlf_stream_if.sink                      detection,
	tvlf_stream_if.source                    report
);
	import tvlf_pkg::*;

	localparam int IW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
	localparam int LW = ($clog2(MAX_HISTORY + 1) > HLEN_W) ? $clog2(MAX_HISTORY + 1) : HLEN_W;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_HISTORY);

	function automatic logic [15:0] abs_diff(logic signed [15:0] a, logic signed [15:0] b);
		logic signed [16:0] d;
		d = 17'(a) - 17'(b);
		return (d < 0) ? 16'(-d) : 16'(d);
	endfunction

	// configuration
	logic [7:0]        thr_q;
	logic [14:0]       max_range_q;
	logic [14:0]       min_range_q;
	logic [15:0]       max_shift_q;
	logic [HLEN_W-1:0] hist_len_q;
	logic [23:0]       max_gap_q;

	// control
	state_t          state_q, state_d;
	logic [2:0]      step_q;
	logic [IW-1:0]   idx_q;
	logic            pend_q;
	logic [LW-1:0]   match_q;
	action_t         act_q;
	logic            store_q;
	logic [IW-1:0]   wp_q;
	logic [7:0]      lock_q;
	logic [1:0]      mode_q;
	logic            out_vld_q;
	logic [MAX_HISTORY-1:0] vld_q;

	// datapath
	logic signed [15:0] x_q, y_q, z_q;
	logic [23:0]        gap_q;
	logic [31:0]        prod_q;
	logic [33:0]        acc_q;
	logic [29:0]        hi2_q, lo2_q;
	logic [31:0]        lim2_q;
	logic [47:0]        mem [MAX_HISTORY];
	logic [47:0]        rd_data_q;
	logic               rd_valid_q;
	res_item_t          out_q;

	logic [LW-1:0]      hl, n_len;
	logic               idx_last;
	logic signed [15:0] hx, hy, hz;
	logic [15:0]        mul_op;
	logic [31:0]        mul_full;
	logic [IW-1:0]      rd_addr;
	logic               rd_en;
	logic [33:0]        dist_sum;
	logic               hit, cmp_en;
	logic               in_range, gap_over;
	logic               accept, out_free, update;
	logic [7:0]         lower_cnt, raise_base;
	logic [8:0]         raise_sum;
	res_item_t          res_d;
	logic [IW-1:0]      wp_next;

	assign accept   = detection.valid && detection.ready;
	assign out_free = !out_vld_q || report.ready;
	assign update   = (state_q == S_UPDATE) && out_free;

	assign hl       = LW'(hist_len_q);
	assign n_len    = (hl == '0) ? LW'(1) : ((hl > MAX_LEN) ? MAX_LEN : hl);
	assign idx_last = (LW'(idx_q) == n_len - LW'(1));

	assign hx = rd_valid_q ? signed'(rd_data_q[47:32]) : '0;
	assign hy = rd_valid_q ? signed'(rd_data_q[31:16]) : '0;
	assign hz = rd_valid_q ? signed'(rd_data_q[15:0])  : '0;

	assign mul_full = {16'b0, mul_op} * {16'b0, mul_op};
	assign dist_sum = acc_q + 34'(prod_q);
	assign hit      = dist_sum < 34'(lim2_q);
	assign in_range = !((acc_q > 34'(hi2_q)) || (acc_q < 34'(lo2_q)));
	assign gap_over = gap_q > max_gap_q;

	assign lower_cnt  = (lock_q != '0) ? lock_q - 8'd1 : '0;
	assign raise_base = (act_q == ACT_RESTART) ? '0 : lock_q;
	assign raise_sum  = {1'b0, raise_base} + 9'd1;
	assign wp_next    = ((LW'(wp_q) + LW'(1)) >= n_len) ? '0 : wp_q + IW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (detection.valid) state_d = S_NORM;
			S_NORM:   if (step_q == 3'd5) state_d = S_RANGE;
			S_RANGE:  state_d = (!in_range || gap_over) ? S_UPDATE : S_DIST;
			S_DIST:   if (step_q == 3'd2 && idx_last) state_d = S_LAST;
			S_LAST:   state_d = S_UPDATE;
			S_UPDATE: if (out_free) state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mul_op  = '0;
		rd_addr = '0;
		rd_en   = 1'b0;
		cmp_en  = 1'b0;
		unique case (state_q)
			S_NORM: begin
				unique case (step_q)
					3'd0:    mul_op = abs_diff(x_q, '0);
					3'd1:    mul_op = abs_diff(y_q, '0);
					3'd2:    mul_op = abs_diff(z_q, '0);
					3'd3:    mul_op = {1'b0, max_range_q};
					3'd4:    mul_op = {1'b0, min_range_q};
					3'd5:    mul_op = max_shift_q;
					default: mul_op = '0;
				endcase
			end
			S_RANGE: begin
				rd_en = 1'b1;
			end
			S_DIST: begin
				unique case (step_q)
					3'd0:    mul_op = abs_diff(x_q, hx);
					3'd1:    mul_op = abs_diff(y_q, hy);
					3'd2:    mul_op = abs_diff(z_q, hz);
					default: mul_op = '0;
				endcase
				cmp_en = (step_q == 3'd0) && pend_q;
				if (step_q == 3'd2) begin
					rd_en   = 1'b1;
					rd_addr = idx_last ? '0 : idx_q + IW'(1);
				end
			end
			S_LAST:   cmp_en = 1'b1;
			default: ;
		endcase
	end

	// result of the lock update
	always_comb begin
		res_d.match_count = 6'(match_q);
		if (act_q == ACT_LOWER) begin
			res_d.lock_count = lower_cnt;
			res_d.new_track  = (lower_cnt == '0);
			res_d.track_mode = (lower_cnt == '0) ? MODE_STOPPING : MODE_IDLING;
		end else begin
			res_d.new_track = (act_q == ACT_RESTART);
			if (raise_sum > {1'b0, thr_q}) begin
				res_d.lock_count = thr_q;
				res_d.track_mode = MODE_TRACKING;
			end else begin
				res_d.lock_count = raise_sum[7:0];
				res_d.track_mode = MODE_IDLING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= LOCK_THRESHOLD_RST;
			max_range_q <= MAX_RANGE_RST;
			min_range_q <= MIN_RANGE_RST;
			max_shift_q <= MAX_SHIFT_RST;
			hist_len_q  <= HISTORY_LENGTH_RST;
			max_gap_q   <= MAX_GAP_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_LOCK_THRESHOLD: thr_q       <= wr_data[7:0];
				REG_MAX_RANGE:      max_range_q <= wr_data[14:0];
				REG_MIN_RANGE:      min_range_q <= wr_data[14:0];
				REG_MAX_SHIFT:      max_shift_q <= wr_data[15:0];
				REG_HISTORY_LENGTH: hist_len_q  <= wr_data[HLEN_W-1:0];
				REG_MAX_GAP:        max_gap_q   <= wr_data[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			idx_q     <= '0;
			pend_q    <= 1'b0;
			match_q   <= '0;
			act_q     <= ACT_LOWER;
			store_q   <= 1'b0;
			wp_q      <= '0;
			lock_q    <= '0;
			mode_q    <= MODE_STOPPING;
			out_vld_q <= 1'b0;
			vld_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						idx_q   <= '0;
						pend_q  <= 1'b0;
						match_q <= '0;
					end
				end
				S_NORM: step_q <= step_q + 3'd1;
				S_RANGE: begin
					step_q <= '0;
					if (!in_range) begin
						act_q   <= ACT_LOWER;
						store_q <= 1'b0;
					end else if (gap_over) begin
						act_q   <= ACT_RESTART;
						store_q <= 1'b1;
					end else begin
						act_q   <= ACT_RAISE;
						store_q <= 1'b1;
					end
				end
				S_DIST: begin
					if (cmp_en && hit) match_q <= match_q + LW'(1);
					if (step_q == 3'd2) begin
						step_q <= '0;
						pend_q <= 1'b1;
						if (!idx_last) idx_q <= idx_q + IW'(1);
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_LAST: begin
					if (hit) match_q <= match_q + LW'(1);
					if (match_q == '0 && !hit) act_q <= ACT_LOWER;
				end
				S_UPDATE: begin
					if (out_free) begin
						lock_q <= res_d.lock_count;
						mode_q <= res_d.track_mode;
						if (store_q) begin
							vld_q[wp_q] <= 1'b1;
							wp_q        <= wp_next;
						end
					end
				end
				default: ;
			endcase
			if (update) out_vld_q <= 1'b1;
			else if (report.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= detection.data.x_pos;
			y_q   <= detection.data.y_pos;
			z_q   <= detection.data.z_pos;
			gap_q <= detection.data.gap_time;
		end
		prod_q <= mul_full;
		if (state_q == S_NORM) begin
			unique case (step_q)
				3'd1:    acc_q <= 34'(prod_q);
				3'd2:    acc_q <= acc_q + 34'(prod_q);
				3'd3:    acc_q <= acc_q + 34'(prod_q);
				3'd4:    hi2_q <= prod_q[29:0];
				3'd5:    lo2_q <= prod_q[29:0];
				default: ;
			endcase
		end
		if (state_q == S_RANGE) lim2_q <= prod_q;
		if (state_q == S_DIST) begin
			if (step_q == 3'd1) acc_q <= 34'(prod_q);
			if (step_q == 3'd2) acc_q <= acc_q + 34'(prod_q);
		end
		if (update) out_q <= res_d;
	end

	// history memory
	always_ff @(posedge clk) begin
		if (update && store_q) mem[wp_q] <= {x_q, y_q, z_q};
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			rd_valid_q <= vld_q[rd_addr];
		end
	end

	assign detection.ready = (state_q == S_IDLE);
	assign report.valid    = out_vld_q;
	assign report.data     = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_STOPPING) |-> (lock_q == '0))
		else $error("stopping mode with nonzero lock count");

	assert property (@(posedge clk) disable iff (!arst_n)
		LW'(wp_q) < MAX_LEN)
		else $error("write pointer beyond history depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIST) |-> (LW'(idx_q) < n_len))
		else $error("scan index beyond history length");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.new_track) |-> (out_q.match_count == '0))
		else $error("new track reported with matches");

endmodule

[test/tvlf_report_checker.sv]
`timescale 1ns / 100ps
// Report checker for the track validity lock filter: watches the register
// writes and both stream channels, predicts each report and compares it.
// Depends on tvlf_pkg for the item types, register indexes and mode codes.
module tvlf_report_checker #(
	parameter int MAX_HISTORY = tvlf_pkg::MAX_HISTORY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [tvlf_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [tvlf_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                            det_valid,
	input  logic                            det_ready,
	input  tvlf_pkg::det_item_t             det_data,
	input  logic                            rpt_valid,
	input  logic                            rpt_ready,
	input  tvlf_pkg::res_item_t             rpt_data,
	output int                              fail_count,
	output int                              pending
);
	import tvlf_pkg::*;

	logic [7:0]  cfg_thr;
	logic [14:0] cfg_max_rng;
	logic [14:0] cfg_min_rng;
	logic [15:0] cfg_shift;
	logic [5:0]  cfg_hlen;
	logic [23:0] cfg_gap;

	logic signed [15:0] hist_x [MAX_HISTORY];
	logic signed [15:0] hist_y [MAX_HISTORY];
	logic signed [15:0] hist_z [MAX_HISTORY];
	int         wr_ptr;
	logic [7:0] lock_cnt;
	logic [1:0] mode_q;

	res_item_t due_reports [$];
	res_item_t want;
	int        mismatches = 0;
	int        k;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		if (mismatches < 200)
			$display("report mismatch on %s: got %0d, expected %0d (t=%0t)",
				what, got, exp_val, $time);
		mismatches++;
	endtask

	function automatic longint unsigned coord_sq(input logic signed [15:0] a,
			input logic signed [15:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return d * d;
	endfunction

	function automatic int span_len();
		if (cfg_hlen < 1)
			return 1;
		if (cfg_hlen > MAX_HISTORY)
			return MAX_HISTORY;
		return int'(cfg_hlen);
	endfunction

	function automatic void lock_up();
		int c;
		c = int'(lock_cnt) + 1;
		if (c > int'(cfg_thr)) begin
			lock_cnt = cfg_thr;
			mode_q = MODE_TRACKING;
		end else begin
			lock_cnt = c[7:0];
			mode_q = MODE_IDLING;
		end
	endfunction

	function automatic void lock_down();
		if (lock_cnt > 0)
			lock_cnt = lock_cnt - 8'd1;
		mode_q = (lock_cnt == 0) ? MODE_STOPPING : MODE_IDLING;
	endfunction

	function automatic void keep_position(input det_item_t d);
		int n;
		n = span_len();
		hist_x[wr_ptr] = d.x_pos;
		hist_y[wr_ptr] = d.y_pos;
		hist_z[wr_ptr] = d.z_pos;
		wr_ptr = (wr_ptr + 1 >= n) ? 0 : wr_ptr + 1;
	endfunction

	function automatic res_item_t predict_report(input det_item_t d);
		res_item_t r;
		longint unsigned norm2, hi2, lo2, lim2, d2;
		int hits, n, i;
		hits = 0;
		r.new_track = 1'b0;
		norm2 = coord_sq(d.x_pos, 16'sd0) + coord_sq(d.y_pos, 16'sd0)
			+ coord_sq(d.z_pos, 16'sd0);
		hi2 = 64'(cfg_max_rng) * 64'(cfg_max_rng);
		lo2 = 64'(cfg_min_rng) * 64'(cfg_min_rng);
		if (norm2 > hi2 || norm2 < lo2) begin
			lock_down();
			r.new_track = (mode_q == MODE_STOPPING);
		end else if (d.gap_time > cfg_gap) begin
			lock_cnt = 8'd0;
			mode_q = MODE_STOPPING;
			lock_up();
			keep_position(d);
			r.new_track = 1'b1;
		end else begin
			n = span_len();
			lim2 = 64'(cfg_shift) * 64'(cfg_shift);
			for (i = 0; i < n; i++) begin
				d2 = coord_sq(d.x_pos, hist_x[i]) + coord_sq(d.y_pos, hist_y[i])
					+ coord_sq(d.z_pos, hist_z[i]);
				if (d2 < lim2)
					hits++;
			end
			if (hits == 0) begin
				lock_down();
				r.new_track = (mode_q == MODE_STOPPING);
			end else begin
				lock_up();
			end
			keep_position(d);
		end
		r.lock_count = lock_cnt;
		r.track_mode = mode_q;
		r.match_count = hits[5:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_reports.delete();
			for (k = 0; k < MAX_HISTORY; k++) begin
				hist_x[k] = '0;
				hist_y[k] = '0;
				hist_z[k] = '0;
			end
			wr_ptr = 0;
			lock_cnt = 8'd0;
			mode_q = MODE_STOPPING;
			cfg_thr = LOCK_THRESHOLD_RST;
			cfg_max_rng = MAX_RANGE_RST;
			cfg_min_rng = MIN_RANGE_RST;
			cfg_shift = MAX_SHIFT_RST;
			cfg_hlen = HISTORY_LENGTH_RST;
			cfg_gap = MAX_GAP_RST;
			pending <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_LOCK_THRESHOLD: cfg_thr = wr_data[7:0];
					REG_MAX_RANGE:      cfg_max_rng = wr_data[14:0];
					REG_MIN_RANGE:      cfg_min_rng = wr_data[14:0];
					REG_MAX_SHIFT:      cfg_shift = wr_data[15:0];
					REG_HISTORY_LENGTH: cfg_hlen = wr_data[5:0];
					REG_MAX_GAP:        cfg_gap = wr_data[23:0];
					default: ;
				endcase
			end
			if (det_valid && det_ready)
				due_reports.push_back(predict_report(det_data));
			if (rpt_valid && rpt_ready) begin
				if (due_reports.size() == 0) begin
					report_mismatch("report with none due", 1, 0);
				end else begin
					want = due_reports.pop_front();
					if (rpt_data.new_track !== want.new_track)
						report_mismatch("new_track", rpt_data.new_track, want.new_track);
					if (rpt_data.lock_count !== want.lock_count)
						report_mismatch("lock_count", rpt_data.lock_count, want.lock_count);
					if (rpt_data.track_mode !== want.track_mode)
						report_mismatch("track_mode", rpt_data.track_mode, want.track_mode);
					if (rpt_data.match_count !== want.match_count)
						report_mismatch("match_count", rpt_data.match_count,
							want.match_count);
				end
			end
			pending <= due_reports.size();
		end
	end

endmodule

[test/track_validity_lock_filter_unit_tb.sv]
`timescale 1ns / 100ps
// Top of the track validity lock filter testbench: clock, reset, register
// programming, detection stimulus, report back-pressure, watchdog, verdict.
// Depends on tvlf_pkg, tvlf_stream_if, the unit and tvlf_report_checker.
module track_validity_lock_filter_unit_tb;
	import tvlf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 120;
	localparam logic [CFG_IDX_W-1:0] BAD_INDEX_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] BAD_INDEX_HI = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  rpt_ready = 1'b0;
	bit                    quiet = 1'b0;
	int                    stall_left = 0;
	int                    idle_cycles = 0;
	int                    cfg [6];
	int                    cur_x = 0;
	int                    cur_y = 0;
	int                    cur_z = 0;
	int                    sent = 0;
	int                    settings = 0;
	int                    fails;
	int                    pending;
	int                    p;

	tvlf_stream_if #(.payload_t(det_item_t)) det_if ();
	tvlf_stream_if #(.payload_t(res_item_t)) rpt_if ();

	assign rpt_if.ready = rpt_ready;

	track_validity_lock_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.detection (det_if),
		.report    (rpt_if)
	);

	tvlf_report_checker report_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.det_valid  (det_if.valid),
		.det_ready  (det_if.ready),
		.det_data   (det_if.data),
		.rpt_valid  (rpt_if.valid),
		.rpt_ready  (rpt_if.ready),
		.rpt_data   (rpt_if.data),
		.fail_count (fails),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rpt_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rpt_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 6);
			rpt_ready <= 1'b0;
		end else begin
			rpt_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((det_if.valid && det_if.ready) || (rpt_if.valid && rpt_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic signed [15:0] clamp16(input int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic det_item_t mk_det(input int x, input int y, input int z,
			input int gap);
		det_item_t d;
		d.x_pos = clamp16(x);
		d.y_pos = clamp16(y);
		d.z_pos = clamp16(z);
		d.gap_time = 24'(gap);
		return d;
	endfunction

	function automatic det_item_t pick_det();
		det_item_t d;
		int kind, half, jit;
		kind = $urandom_range(0, 9);
		half = cfg[REG_MAX_RANGE] / 2;
		jit = cfg[REG_MAX_SHIFT] / 3 + 1;
		if (jit > 8000)
			jit = 8000;
		if (kind == 2) begin
			cur_x = int'($urandom_range(0, 2 * half)) - half;
			cur_y = int'($urandom_range(0, 2 * half)) - half;
			cur_z = int'($urandom_range(0, 2 * half)) - half;
		end else if (kind >= 3) begin
			cur_x = int'(clamp16(cur_x + int'($urandom_range(0, 2 * jit)) - jit));
			cur_y = int'(clamp16(cur_y + int'($urandom_range(0, 2 * jit)) - jit));
			cur_z = int'(clamp16(cur_z + int'($urandom_range(0, 2 * jit)) - jit));
		end
		d = mk_det(cur_x, cur_y, cur_z, $urandom_range(0, cfg[REG_MAX_GAP]));
		if (kind == 1 && cfg[REG_MAX_GAP] < 24'hFFFFFF)
			d.gap_time = 24'($urandom_range(cfg[REG_MAX_GAP] + 1, 24'hFFFFFF));
		if (kind == 0) begin
			d.x_pos = 16'($urandom);
			d.y_pos = 16'($urandom);
			d.z_pos = 16'($urandom);
			d.gap_time = 24'($urandom);
		end
		return d;
	endfunction

	task automatic send_det(input det_item_t d);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			det_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		det_if.valid <= 1'b1;
		det_if.data <= d;
		do @(posedge clk); while (!det_if.ready);
		sent++;
	endtask

	task automatic hold_until_drained();
		det_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic program_regs(input int thr, input int rmax, input int rmin,
			input int shift, input int hlen, input int gap);
		int vals [6];
		logic [CFG_DATA_W-1:0] mask;
		int i;
		vals = '{thr, rmax, rmin, shift, hlen, gap};
		for (i = 0; i < 6; i++) begin
			case (reg_index_t'(i))
				REG_LOCK_THRESHOLD: mask = 24'hFF;
				REG_MAX_RANGE:      mask = 24'h7FFF;
				REG_MIN_RANGE:      mask = 24'h7FFF;
				REG_MAX_SHIFT:      mask = 24'hFFFF;
				REG_HISTORY_LENGTH: mask = 24'h3F;
				default:            mask = 24'hFFFFFF;
			endcase
			wr_en <= 1'b1;
			wr_index <= reg_index_t'(i);
			wr_data <= (24'(vals[i]) & mask) | (24'($urandom) & ~mask);
			@(posedge clk);
		end
		wr_index <= ($urandom_range(0, 1) != 0) ? BAD_INDEX_LO : BAD_INDEX_HI;
		wr_data <= 24'($urandom);
		@(posedge clk);
		wr_en <= 1'b0;
		cfg = vals;
		settings++;
	endtask

	task automatic run_items(input int count);
		int n;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 59) == 0)
				hold_until_drained();
			send_det(pick_det());
		end
		hold_until_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_LOCK_THRESHOLD;
		wr_data = '0;
		det_if.valid = 1'b0;
		det_if.data = '0;
		cfg[REG_LOCK_THRESHOLD] = LOCK_THRESHOLD_RST;
		cfg[REG_MAX_RANGE] = MAX_RANGE_RST;
		cfg[REG_MIN_RANGE] = MIN_RANGE_RST;
		cfg[REG_MAX_SHIFT] = MAX_SHIFT_RST;
		cfg[REG_HISTORY_LENGTH] = HISTORY_LENGTH_RST;
		cfg[REG_MAX_GAP] = MAX_GAP_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_det(mk_det(0, 0, 0, 0));
		send_det(mk_det(-32768, -32768, -32768, 0));
		send_det(mk_det(32767, 32767, 32767, 24'hFFFFFF));
		send_det(mk_det(100, 100, 100, 24'hFFFFFF));
		for (p = 0; p < 7; p++)
			send_det(mk_det(100, 100, 100 + p, MAX_GAP_RST));
		send_det(mk_det(10000, 0, 0, MAX_GAP_RST + 1));
		send_det(mk_det(-10000, 5000, 0, 0));
		send_det(mk_det(-10000, -5000, 0, 0));
		send_det(mk_det(5000, 5000, 5000, 0));
		send_det(mk_det(20000, 0, 0, 0));
		send_det(mk_det(0, 0, -20000, 0));
		send_det(mk_det(0, 0, 20001, 0));
		send_det(mk_det(-1, -1, -1, 0));
		hold_until_drained();

		program_regs(0, 32767, 0, 65535, 32, 24'hFFFFFF);
		run_items(60);
		program_regs(255, 0, 0, 0, 1, 0);
		run_items(40);
		program_regs(4, 1000, 2000, 500, 20, 100000);
		run_items(30);
		program_regs(8, 30000, 5000, 2000, 63, 50000);
		run_items(60);
		program_regs(6, 25000, 0, 3000, 32, 200000);
		run_items(60);
		program_regs(3, 25000, 0, 3000, 4, 200000);
		run_items(60);
		program_regs(2, 32767, 0, 1, 0, 1000);
		run_items(40);
		for (p = 0; p < 5; p++) begin
			program_regs(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
					: $urandom_range(1, 10),
				$urandom_range(2000, 32767), $urandom_range(0, 1000),
				$urandom_range(50, 6000), $urandom_range(0, 63),
				$urandom_range(0, 24'hFFFFFF));
			run_items(80);
		end
		quiet = 1'b1;
		program_regs(LOCK_THRESHOLD_RST, MAX_RANGE_RST, MIN_RANGE_RST, MAX_SHIFT_RST,
			HISTORY_LENGTH_RST, MAX_GAP_RST);
		run_items(80);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d detection items under %0d register settings,", sent, settings);
		$display("range rejects, gap restarts, history matches and lock saturation");
		if (fails == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
